[sv/record_sorter_by_key_assert.svh]
// Assertion macros of the record sorter checker
`ifndef RECORD_SORTER_BY_KEY_ASSERT_SVH
`define RECORD_SORTER_BY_KEY_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define RSBK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define RSBK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rsbk_pkg.sv]
// Shared types and constants of the record sorter
package rsbk_pkg;

  localparam int MAX_ROWS = 64;
  localparam int KEY_BITS = 32;
  localparam int TAG_BITS = 16;
  localparam int OUT_KEY_BITS = 32;
  localparam int CNT_W = $clog2(MAX_ROWS + 1);

  // One record as held in a cell
  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } rec_t;

  // Per-cycle command broadcast along the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

[sv/rsbk_cell.sv]
// One cell of the insertion chain: holds a record, inserts or shifts it
module rsbk_cell (
  input  logic              clk,
  input  logic              rst,
  input  rsbk_pkg::cell_ctrl_t ctrl,
  input  rsbk_pkg::rec_t    new_rec,
  input  rsbk_pkg::rec_t    prev_rec,
  input  logic              prev_ins,
  input  rsbk_pkg::rec_t    next_rec,
  output rsbk_pkg::rec_t    rec,
  output logic              ins
);
  import rsbk_pkg::*;

  logic                valid;
  logic [KEY_BITS-1:0] key;
  logic [TAG_BITS-1:0] tag;
  logic                displaced;

  // Strictly smaller new key moves this record on; equal keys stay put
  assign displaced = valid && ($signed(new_rec.key) < $signed(key));
  assign ins       = displaced || !valid;
  assign rec       = '{valid: valid, key: key, tag: tag};

  // Valid bit: control state, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_rec.valid;
    end else if (ctrl.insert && ins) begin
      valid <= prev_ins ? prev_rec.valid : 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key <= next_rec.key;
      tag <= next_rec.tag;
    end else if (ctrl.insert && ins) begin
      key <= prev_ins ? prev_rec.key : new_rec.key;
      tag <= prev_ins ? prev_rec.tag : new_rec.tag;
    end
  end

endmodule

[sv/record_sorter_by_key.sv]
// Record sorter: stable ascending sort of up to MAX_ROWS keyed records
//
// Input: a record (key, row_tag, is_last) is transferred at a rising edge
// with start high and busy low. Loading takes one record per cycle while
// busy is low: a chain of MAX_ROWS cells places each record in key order
// in the same cycle. Records beyond MAX_ROWS are dropped and the set is
// marked overflowed. A record with is_last ends the set (it is stored
// first if room remains). Output: busy is high from the edge of the
// is_last transfer, and the chain shifts one record per cycle towards
// cell 0. Each result sits on sorted_key/sorted_tag/last_out/overflow for
// one cycle with strobe high; the first result is registered from cell 0
// once the state machine is in emission. N stored records give N results
// on consecutive cycles, the last with last_out set. busy stays high
// while the chain shifts and is already low while the final result is
// shown. Equal keys leave in arrival order. The receiver cannot stall, so
// results are never held. Reset empties the chain, clears the count and
// the overflow mark and drops any emission in progress.
module record_sorter_by_key (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] key,
  input  logic [15:0] row_tag,
  input  logic        is_last,
  output logic        strobe,
  output logic [31:0] sorted_key,
  output logic [15:0] sorted_tag,
  output logic        last_out,
  output logic        overflow
);
  import rsbk_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic             dropped;
  logic             accept;
  logic             room;
  cell_ctrl_t       ctrl;
  rec_t             new_rec;
  rec_t             cell_rec  [MAX_ROWS];
  rec_t             prev_rec  [MAX_ROWS];
  rec_t             next_rec  [MAX_ROWS];
  logic             cell_ins  [MAX_ROWS];
  logic             prev_ins  [MAX_ROWS];

  assign accept  = start && !busy;
  assign room    = count < CNT_W'(MAX_ROWS);
  assign new_rec = '{valid: 1'b1, key: key[KEY_BITS-1:0], tag: row_tag};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (accept && is_last) state_next = ST_EMIT;
      ST_EMIT: if (count == CNT_W'(1)) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    busy        = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    unique case (state)
      ST_LOAD: ctrl.insert = start && room;
      ST_EMIT: begin
        busy       = 1'b1;
        ctrl.shift = 1'b1;
      end
      default: ;
    endcase
  end

  // State, record count and overflow mark
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) dropped <= 1'b0;
      end else if (accept) begin
        if (room) count <= count + CNT_W'(1);
        else      dropped <= 1'b1;
      end
    end
  end

  // Neighbour wiring of the chain
  always_comb begin
    for (int i = 0; i < MAX_ROWS; i++) begin
      prev_rec[i] = (i == 0) ? '0 : cell_rec[(i == 0) ? 0 : i - 1];
      prev_ins[i] = (i == 0) ? 1'b0 : cell_ins[(i == 0) ? 0 : i - 1];
      next_rec[i] = (i == MAX_ROWS - 1) ? '0 : cell_rec[(i == MAX_ROWS - 1) ? i : i + 1];
    end
  end

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    rsbk_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .new_rec  (new_rec),
      .prev_rec (prev_rec[g]),
      .prev_ins (prev_ins[g]),
      .next_rec (next_rec[g]),
      .rec      (cell_rec[g]),
      .ins      (cell_ins[g])
    );
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= (state == ST_EMIT);
  end

  // Result payload, taken from the head of the chain
  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      sorted_key <= OUT_KEY_BITS'($signed(cell_rec[0].key));
      sorted_tag <= cell_rec[0].tag;
      last_out   <= (count == CNT_W'(1));
      overflow   <= dropped;
    end
  end

endmodule

[sv/rsbk_checker.sv]
// Port-level checks of the record sorter, bound to the top level
`include "record_sorter_by_key_assert.svh"

module rsbk_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        is_last,
  input logic        strobe,
  input logic        last_out
);

  // Closing transfer of a set always starts an emission
  `RSBK_ASSERT_NEXT(a_last_starts_emit, start && !busy && is_last, busy, "no emission after is_last")

  // More results still to come keep the block busy
  `RSBK_ASSERT_NOW(a_mid_run_busy, strobe && !last_out, busy, "busy dropped inside a run")

  // The closing result finds the block ready again
  `RSBK_ASSERT_NOW(a_last_idle, strobe && last_out, !busy, "still busy at final result")

  // Leaving emission coincides with the final result
  `RSBK_ASSERT_NOW(a_fall_last, $fell(busy), strobe && last_out, "emission ended without last_out")

endmodule

bind record_sorter_by_key rsbk_checker u_rsbk_checker (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for the record sorter: directed and random sets against a stable-sort predictor
module testbench;
  import rsbk_pkg::*;

  // One record waiting to be transferred, with the idle chance of its phase
  typedef struct {
    logic [31:0] key;
    logic [15:0] tag;
    logic        last;
    int unsigned idle_pct;
  } load_item_t;

  // One sorted record as the block should emit it
  typedef struct {
    logic [31:0] key;
    logic [15:0] tag;
    logic        last;
    logic        ovf;
  } sorted_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] key = '0;
  logic [15:0] row_tag = '0;
  logic        is_last = 1'b0;
  logic        busy;
  logic        strobe;
  logic [31:0] sorted_key;
  logic [15:0] sorted_tag;
  logic        last_out;
  logic        overflow;

  load_item_t                 load_q[$];
  sorted_rec_t                sorted_due[$];
  logic signed [KEY_BITS-1:0] set_keys[$];
  logic [TAG_BITS-1:0]        set_tags[$];
  logic                       set_dropped = 1'b0;
  int unsigned                phase_idle = 0;
  int unsigned                items_total = 0;
  int unsigned                items_loaded = 0;
  int unsigned                fail_n = 0;

  record_sorter_by_key dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .key(key), .row_tag(row_tag), .is_last(is_last),
    .strobe(strobe), .sorted_key(sorted_key), .sorted_tag(sorted_tag),
    .last_out(last_out), .overflow(overflow)
  );

  always #4 clk = ~clk;

  // Stable insertion of one transferred record; a set end releases the sorted run
  function automatic void place_record(logic [31:0] k, logic [15:0] t, logic lst);
    int          pos;
    sorted_rec_t r;
    if (set_keys.size() < MAX_ROWS) begin
      pos = set_keys.size();
      // equal keys stay ahead of the newcomer
      while (pos > 0 && set_keys[pos-1] > $signed(k[KEY_BITS-1:0])) pos--;
      set_keys.insert(pos, k[KEY_BITS-1:0]);
      set_tags.insert(pos, t);
    end else begin
      set_dropped = 1'b1;
    end
    if (lst) begin
      foreach (set_keys[i]) begin
        r.key  = 32'(set_keys[i]);
        r.tag  = set_tags[i];
        r.last = (i == set_keys.size() - 1);
        r.ovf  = set_dropped;
        sorted_due = {sorted_due, r};
      end
      set_keys.delete();
      set_tags.delete();
      set_dropped = 1'b0;
    end
  endfunction

  function automatic void add_record(logic [31:0] k, logic [15:0] t, logic lst);
    load_item_t it;
    it.key = k;
    it.tag = t;
    it.last = lst;
    it.idle_pct = phase_idle;
    load_q = {load_q, it};
    items_total++;
  endfunction

  // Keys: full range, a narrow band around zero for ties, and near the extremes
  function automatic logic [31:0] pick_key();
    case ($urandom_range(3))
      0: return 32'($urandom_range(4)) - 32'd2;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF - 32'($urandom_range(2))
                                  : 32'h8000_0000 + 32'($urandom_range(2));
      default: return $urandom();
    endcase
  endfunction

  function automatic void mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    fail_n++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
  endfunction

  // Driver: hold a record while busy, else present the next one unless the phase asks for an idle cycle
  always @(posedge clk) begin : drive
    load_item_t nxt;
    if (!rst) begin
      if (start && !busy) begin
        place_record(key, row_tag, is_last);
        items_loaded++;
      end
      if (!(start && busy)) begin
        if (load_q.size() != 0 && $urandom_range(99) >= load_q[0].idle_pct) begin
          nxt = load_q.pop_front();
          start   <= 1'b1;
          key     <= nxt.key;
          row_tag <= nxt.tag;
          is_last <= nxt.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result against the oldest expectation
  always @(posedge clk) begin : watch
    sorted_rec_t exp_r;
    if (!rst && strobe) begin
      if (sorted_due.size() == 0) begin
        mismatch("unexpected result, key", 32'hx, sorted_key);
      end else begin
        exp_r = sorted_due.pop_front();
        if (sorted_key !== exp_r.key)  mismatch("sorted_key", exp_r.key, sorted_key);
        if (sorted_tag !== exp_r.tag)  mismatch("sorted_tag", 32'(exp_r.tag), 32'(sorted_tag));
        if (last_out !== exp_r.last)   mismatch("last_out", 32'(exp_r.last), 32'(last_out));
        if (overflow !== exp_r.ovf)    mismatch("overflow", 32'(exp_r.ovf), 32'(overflow));
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int unsigned idle_by_phase[4];
    int unsigned n_rand;
    int unsigned set_no;
    int unsigned set_len;

    idle_by_phase = '{0, 57, 0, 19};
    // directed: single records at both extremes
    add_record(32'h8000_0000, 16'h0000, 1'b1);
    add_record(32'h7FFF_FFFF, 16'hFFFF, 1'b1);
    // extremes, zero and the values either side of it
    add_record(32'h7FFF_FFFF, 16'h0010, 1'b0);
    add_record(32'h8000_0000, 16'h0011, 1'b0);
    add_record(32'h0000_0000, 16'hFFFF, 1'b0);
    add_record(32'hFFFF_FFFF, 16'h0000, 1'b0);
    add_record(32'h0000_0001, 16'h0013, 1'b1);
    // ties must leave in arrival order
    phase_idle = idle_by_phase[1];
    add_record(32'd5, 16'd1, 1'b0);
    add_record(32'd5, 16'd2, 1'b0);
    add_record(-32'sd3, 16'd3, 1'b0);
    add_record(32'd5, 16'd4, 1'b0);
    add_record(-32'sd3, 16'd5, 1'b0);
    add_record(32'd5, 16'd6, 1'b1);
    // already ascending, then descending
    phase_idle = idle_by_phase[3];
    for (int i = 0; i < 4; i++) add_record(32'h0001_0000 * i, 16'(i), i == 3);
    for (int i = 0; i < 4; i++) add_record(32'h0001_0000 * (3 - i), 16'(i), i == 3);

    // random sets: mostly short, one that fills the chain and runs over capacity
    n_rand = 0;
    set_no = 0;
    while (n_rand < 109) begin
      phase_idle = idle_by_phase[(set_no / 2) % 4];
      if (set_no == 4) set_len = MAX_ROWS + 2;
      else             set_len = $urandom_range(1, 8);
      for (int i = 0; i < set_len; i++)
        add_record(pick_key(), 16'($urandom_range(65535)), i == set_len - 1);
      n_rand += set_len;
      set_no++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (items_loaded != items_total) @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (MAX_ROWS + 8) @(posedge clk);
    if (fail_n == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin : watchdog
    #(8 * 60000);
    $display("status: fail");
    $finish;
  end

endmodule
